[src/irf_pkg.sv]
// Shared constants of the image rotate and flip unit: field widths, modes, register indexes.
package irf_pkg;

    // Fixed widths of the port fields.
    localparam int PIX_W   = 16;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 2;
    localparam int MODE_W  = 3;

    // Transform modes.
    localparam logic [MODE_W-1:0] MODE_ROT90   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROT180  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT270  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLIP_R  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLIP_C  = 3'd4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Opcodes of an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage

[src/image_rotate_flip.sv]
// Top level of the image rotate and flip unit: one frame store with raster write and transformed read.
// Throughput is one item per clock cycle, writes and reads in any mix; busy is low except in reset.
// A write item is written to the store in the cycle after it is accepted and yields no result.
// A read item's result appears on the strobe after the registered source coordinates, then the address
// multiply and registered read of the single-port-read frame store, and results are never held off.
// Synchronous active-low reset clears the pointers, the pipeline and the registers (mode 0,
// 256 by 256); the frame store itself is not cleared, so there is no clearing pass after reset.
module image_rotate_flip
    import irf_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Item channel.
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [PIX_W-1:0]  i_pixel_value,
    // Result channel.
    output logic              o_strobe,
    output logic [PIX_W-1:0]  o_pixel_out,
    output logic              o_frame_last,
    // Configuration write port.
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // Row and column index width, width of a side length, store address width.
    localparam int IW    = $clog2(MAX_SIDE);
    localparam int CW    = $clog2(MAX_SIDE + 1);
    localparam int AW    = 2 * IW;
    localparam int TW    = 2 * CW;
    localparam int PW    = IW + CW;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    // Stored pixels keep only the bits that survive both the port and the pixel mask.
    localparam int SW    = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

    // A side length of zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [CW-1:0] clamp_side(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return CW'(1);
        end else if (int'(v) > MAX_SIDE) begin
            return CW'(MAX_SIDE);
        end
        return CW'(v);
    endfunction

    // Configuration, kept already clamped.
    logic [MODE_W-1:0] r_mode;
    logic [CW-1:0]     r_w;
    logic [CW-1:0]     r_h;

    // Raster pointers.
    logic [AW-1:0]     r_wp,      n_wp;
    logic [IW-1:0]     r_out_row, n_out_row;
    logic [IW-1:0]     r_out_col, n_out_col;

    // Pending store write, registered at acceptance.
    logic              r_wr_en;
    logic [AW-1:0]     r_wr_addr;
    logic [SW-1:0]     r_wr_data;

    // Read pipeline: source coordinates, then registered store data.
    logic              r_st1_vld;
    logic              r_st1_last;
    logic [IW-1:0]     r_sr,  n_sr;
    logic [IW-1:0]     r_sc,  n_sc;
    logic              r_out_vld;
    logic              r_out_last;
    logic [SW-1:0]     r_rd_data;
    logic              r_busy;

    logic [SW-1:0]     mem [DEPTH];

    logic              acc, acc_wr, acc_rd;
    logic [TW-1:0]     total;
    logic [AW-1:0]     wp_eff;
    logic [TW-1:0]     wp_inc;
    logic [CW-1:0]     ow, oh;
    logic              pos_ok;
    logic [IW-1:0]     row, col;
    logic [CW-1:0]     row_x, col_x;
    logic [CW-1:0]     sr_x, sc_x;
    logic              n_last;
    logic [PW-1:0]     rd_prod;
    logic [AW-1:0]     rd_addr;

    assign acc    = start && !r_busy;
    assign acc_wr = acc && (i_opcode == OP_WRITE);
    assign acc_rd = acc && (i_opcode == OP_READ);

    // Write side: restart at zero when the pointer has fallen outside a shrunken frame,
    // and wrap after the last pixel.
    assign total  = TW'(r_w) * TW'(r_h);
    assign wp_eff = (TW'(r_wp) >= total) ? '0 : r_wp;
    assign wp_inc = TW'(wp_eff) + TW'(1);
    assign n_wp   = (wp_inc >= total) ? '0 : wp_inc[AW-1:0];

    // Read side: the quarter turns swap the output dimensions.
    always_comb begin
        if (r_mode == MODE_ROT90 || r_mode == MODE_ROT270) begin
            ow = r_h;
            oh = r_w;
        end else begin
            ow = r_w;
            oh = r_h;
        end
    end

    // A position left outside the current output frame restarts at the origin.
    assign pos_ok = (CW'(r_out_row) < oh) && (CW'(r_out_col) < ow);
    assign row    = pos_ok ? r_out_row : '0;
    assign col    = pos_ok ? r_out_col : '0;
    assign row_x  = CW'(row);
    assign col_x  = CW'(col);

    // Map the output position back to its source pixel.
    always_comb begin
        case (r_mode)
            MODE_ROT90: begin
                sr_x = r_h - CW'(1) - col_x;
                sc_x = row_x;
            end
            MODE_ROT180: begin
                sr_x = r_h - CW'(1) - row_x;
                sc_x = r_w - CW'(1) - col_x;
            end
            MODE_ROT270: begin
                sr_x = col_x;
                sc_x = r_w - CW'(1) - row_x;
            end
            MODE_FLIP_R: begin
                sr_x = r_h - CW'(1) - row_x;
                sc_x = col_x;
            end
            MODE_FLIP_C: begin
                sr_x = row_x;
                sc_x = r_w - CW'(1) - col_x;
            end
            default: begin
                // Unused modes pass the frame through unchanged.
                sr_x = row_x;
                sc_x = col_x;
            end
        endcase
    end

    assign n_sr   = sr_x[IW-1:0];
    assign n_sc   = sc_x[IW-1:0];
    assign n_last = (row_x == oh - CW'(1)) && (col_x == ow - CW'(1));

    // Advance in output raster order, wrapping after the last pixel.
    always_comb begin
        if (col_x + CW'(1) >= ow) begin
            n_out_col = '0;
            n_out_row = (row_x + CW'(1) >= oh) ? '0 : IW'(row_x + CW'(1));
        end else begin
            n_out_col = IW'(col_x + CW'(1));
            n_out_row = row;
        end
    end

    // Store address of the source pixel, from the registered coordinates.
    assign rd_prod = PW'(r_sr) * PW'(r_w) + PW'(r_sc);
    assign rd_addr = rd_prod[AW-1:0];

    // Control and pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ROT90;
            r_w        <= CW'(256 > MAX_SIDE ? MAX_SIDE : 256);
            r_h        <= CW'(256 > MAX_SIDE ? MAX_SIDE : 256);
            r_wp       <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_wr_en    <= 1'b0;
            r_st1_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_busy     <= 1'b1;
        end else begin
            r_busy    <= 1'b0;
            r_wr_en   <= acc_wr;
            r_st1_vld <= acc_rd;
            r_out_vld <= r_st1_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE:   r_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_WIDTH:  r_w    <= clamp_side(i_cfg_data);
                    CFG_HEIGHT: r_h    <= clamp_side(i_cfg_data);
                    default: ;
                endcase
            end
            if (acc_wr) begin
                r_wp <= n_wp;
            end
            if (acc_rd) begin
                r_out_row <= n_out_row;
                r_out_col <= n_out_col;
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge i_clk) begin
        if (acc_wr) begin
            r_wr_addr <= wp_eff;
            r_wr_data <= i_pixel_value[SW-1:0];
        end
        if (acc_rd) begin
            r_sr       <= n_sr;
            r_sc       <= n_sc;
            r_st1_last <= n_last;
        end
        r_out_last <= r_st1_last;
    end

    // Frame store: one write port and one registered read port. A write and a read both issue
    // in the cycle after acceptance, so store order follows item order and no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            mem[r_wr_addr] <= r_wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign busy         = r_busy;
    assign o_strobe     = r_out_vld;
    assign o_pixel_out  = PIX_W'(r_rd_data);
    assign o_frame_last = r_out_vld && r_out_last;

    // Every accepted read item gives exactly one result.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_rd |=> ##1 o_strobe)
        else $error("read item produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(acc_rd, 2))
        else $error("result without a read item");

    // The write pointer stays inside the frame after every write without a register write.
    a_wp_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_wr && !i_cfg_we) |=> (TW'(r_wp) < total))
        else $error("write pointer left the frame");

    // The read position stays inside the output frame after every read without a register write.
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_rd && !i_cfg_we) |=> ((CW'(r_out_row) < oh) && (CW'(r_out_col) < ow)))
        else $error("read position left the output frame");

endmodule

[tb/irf_pixel_check.sv]
// Watches the item, result and register channels, predicts each transformed pixel and compares.
`timescale 1ns / 1ps

module irf_pixel_check
    import irf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_opcode,
    input  logic [PIX_W-1:0]  i_pixel_value,
    input  logic              i_strobe,
    input  logic [PIX_W-1:0]  i_pixel_out,
    input  logic              i_frame_last,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int MAX_SIDE    = 256;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_pixel_result;

    // Shadow copy of the frame store, pointers and registers.
    logic [PIX_W-1:0]  frame_mem [0:MAX_SIDE*MAX_SIDE-1];
    int                wr_ptr;
    int                out_row;
    int                out_col;
    logic [MODE_W-1:0] mode_q;
    logic [CFG_W-1:0]  width_q;
    logic [CFG_W-1:0]  height_q;

    t_pixel_result     expected_pixels [$];
    int                errors;

    function automatic int side_of(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic void store_pixel(logic [PIX_W-1:0] pix);
        int total;
        total = side_of(width_q) * side_of(height_q);
        if (wr_ptr >= total) wr_ptr = 0;
        frame_mem[wr_ptr] = pix;
        wr_ptr++;
        if (wr_ptr >= total) wr_ptr = 0;
    endfunction

    // Source pixel for the next output position, then step the output raster.
    function automatic t_pixel_result next_output_pixel();
        int w, h, ow, oh, r, c, sr, sc;
        t_pixel_result res;
        w = side_of(width_q);
        h = side_of(height_q);
        if (mode_q == MODE_ROT90 || mode_q == MODE_ROT270) begin
            ow = h;
            oh = w;
        end else begin
            ow = w;
            oh = h;
        end
        if (out_row >= oh || out_col >= ow) begin
            out_row = 0;
            out_col = 0;
        end
        r = out_row;
        c = out_col;
        case (mode_q)
            MODE_ROT90: begin
                sr = h - 1 - c;
                sc = r;
            end
            MODE_ROT180: begin
                sr = h - 1 - r;
                sc = w - 1 - c;
            end
            MODE_ROT270: begin
                sr = c;
                sc = w - 1 - r;
            end
            MODE_FLIP_R: begin
                sr = h - 1 - r;
                sc = c;
            end
            MODE_FLIP_C: begin
                sr = r;
                sc = w - 1 - c;
            end
            default: begin
                sr = r;
                sc = c;
            end
        endcase
        res.pixel = frame_mem[sr * w + sc];
        res.last  = (r == oh - 1) && (c == ow - 1);
        if (c + 1 >= ow) begin
            out_col = 0;
            out_row = (r + 1 >= oh) ? 0 : r + 1;
        end else begin
            out_col = c + 1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            wr_ptr   = 0;
            out_row  = 0;
            out_col  = 0;
            mode_q   = MODE_ROT90;
            width_q  = CFG_W'(MAX_SIDE);
            height_q = CFG_W'(MAX_SIDE);
            errors   = 0;
            expected_pixels.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:   mode_q   = i_cfg_data[MODE_W-1:0];
                    CFG_WIDTH:  width_q  = i_cfg_data;
                    CFG_HEIGHT: height_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_opcode == OP_WRITE) begin
                    store_pixel(i_pixel_value);
                end else begin
                    expected_pixels.push_back(next_output_pixel());
                end
            end
            if (i_strobe) begin
                if (expected_pixels.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("unexpected result: pixel %h last %b",
                                 i_pixel_out, i_frame_last);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_out !== want.pixel || i_frame_last !== want.last) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("mismatch: expected pixel %h last %b, got pixel %h last %b",
                                     want.pixel, want.last, i_pixel_out, i_frame_last);
                    end
                end
            end
            o_fail_count <= errors;
            o_pending    <= expected_pixels.size();
        end
    end

endmodule

[tb/testbench.sv]
// Top of the rotate and flip testbench: clock, reset, item and register stimulus, watchdog, verdict.
`timescale 1ns / 1ps

module testbench;
    import irf_pkg::*;

    localparam int MAX_SIDE       = 256;
    localparam int ITEM_TARGET    = 1550;
    localparam int WATCHDOG_LIMIT = 2000;
    // The block returns a read through its coordinate and store read registers; the drain also
    // covers the trailing store write before any register is touched.
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_GAP        = 17;
    localparam logic [CIDX_W-1:0] CFG_SPARE = CFG_HEIGHT + 2'd1;
    localparam int MODE_LAST      = (1 << MODE_W) - 1;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_opcode;
    logic [PIX_W-1:0]  i_pixel_value;
    logic              o_strobe;
    logic [PIX_W-1:0]  o_pixel_out;
    logic              o_frame_last;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    int                fail_count;
    int                pending;
    int                items_sent;
    int                idle_cycles;
    bit                no_gaps;

    image_rotate_flip i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_pixel_value (i_pixel_value),
        .o_strobe      (o_strobe),
        .o_pixel_out   (o_pixel_out),
        .o_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // The checker sits beside the block and only observes; it reports how many
    // results failed and how many reads are still waiting for their pixel.
    irf_pixel_check u_pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_opcode      (i_opcode),
        .i_pixel_value (i_pixel_value),
        .i_strobe      (o_strobe),
        .i_pixel_out   (o_pixel_out),
        .i_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The watchdog restarts on any handshake, result or register write. A stuck
    // block, or one that drops a result, ends the run here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // A dimension register of zero acts as one and anything above the store side acts
    // as the full side; the stimulus needs the effective frame size to fill it.
    function automatic int effective_side(int v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    // Present one item and hold it until the block takes it. Between items the
    // sender may idle for a randomly drawn gap; in gap-free stretches start
    // simply stays high from one item to the next.
    task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_pixel_value <= pix;
        do
            @(posedge i_clk);
        while (busy);
        items_sent++;
    endtask

    // Stop sending and wait until every read in flight has returned its pixel.
    // The extra edge lets the checker count a read accepted at the last edge.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Registers change only with the block idle: all results in, and then a drain
    // wait so that the last write item has reached the store.
    task automatic program_frame(input logic [CFG_W-1:0] mode_data,
                                 input logic [CFG_W-1:0] w,
                                 input logic [CFG_W-1:0] h,
                                 input bit spare);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        if (spare) begin
            // The unused index must not disturb any register.
            i_cfg_index <= CFG_SPARE;
            i_cfg_data  <= CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
            @(posedge i_clk);
        end
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= mode_data;
        @(posedge i_clk);
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Write a whole frame. Whatever the write pointer was, this many writes touch
    // every entry of the current frame, so no later read can hit a stale entry.
    task automatic fill_frame(input int count);
        repeat (count) send_item(OP_WRITE, PIX_W'($urandom_range(0, (1 << PIX_W) - 1)));
    endtask

    initial begin
        logic [PIX_W-1:0] corner_pixels [6];
        logic [CFG_W-1:0] mode_data;
        int               phase;
        int               w;
        int               h;
        int               pick;
        int               mode_sel;
        int               mixed;

        corner_pixels = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000, 16'h0001};

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_opcode      <= OP_WRITE;
        i_pixel_value <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_MODE;
        i_cfg_data    <= '0;
        items_sent    = 0;
        no_gaps       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A 3 by 2 frame of extreme pixel values rotated by 90 degrees,
        // read once through to the last pixel and once more to see the position wrap.
        program_frame(CFG_W'(MODE_ROT90), 9'd3, 9'd2, 1'b0);
        foreach (corner_pixels[k]) send_item(OP_WRITE, corner_pixels[k]);
        repeat (7) send_item(OP_READ, PIX_W'($urandom_range(0, (1 << PIX_W) - 1)));

        // Zero width and height act as a 1 by 1 frame; the spare register index is
        // written along the way. Both reads return the single pixel, each marked last.
        program_frame(CFG_W'(MODE_FLIP_C), 9'd0, 9'd0, 1'b1);
        send_item(OP_WRITE, 16'hFFFF);
        send_item(OP_READ, 16'h0000);
        send_item(OP_READ, 16'hFFFF);

        // Random phases: program a frame, fill it, then a random mix of reads and
        // writes. The first phases walk through every mode value, the unused ones
        // included, and the first two take the longest row and the tallest column.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase <= MODE_LAST)
                mode_sel = phase;
            else if ($urandom_range(0, 9) == 0)
                mode_sel = $urandom_range(MODE_FLIP_C + 1, MODE_LAST);
            else
                mode_sel = $urandom_range(MODE_ROT90, MODE_FLIP_C);
            mode_data = CFG_W'(mode_sel);
            // Only the low bits select the mode; junk above them must be ignored.
            if ($urandom_range(0, 3) == 0)
                mode_data[CFG_W-1:MODE_W] =
                    (CFG_W - MODE_W)'($urandom_range(1, (1 << (CFG_W - MODE_W)) - 1));

            pick = (phase == 0) ? 0 : (phase == 1) ? 1 : $urandom_range(0, 19);
            case (pick)
                0: begin
                    w = (phase == 0 || $urandom_range(0, 1) == 0) ? MAX_SIDE
                        : $urandom_range(MAX_SIDE + 1, (1 << CFG_W) - 1);
                    h = 1;
                end
                1: begin
                    w = 1;
                    h = (phase == 1 || $urandom_range(0, 1) == 0) ? MAX_SIDE
                        : $urandom_range(MAX_SIDE + 1, (1 << CFG_W) - 1);
                end
                2: begin
                    w = 0;
                    h = $urandom_range(0, 6);
                end
                3: begin
                    w = $urandom_range(1, 6);
                    h = 0;
                end
                default: begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 12);
                end
            endcase

            program_frame(mode_data, CFG_W'(w), CFG_W'(h), 1'b0);
            // About one phase in four runs without any sender gaps.
            no_gaps = ($urandom_range(0, 3) == 0);
            fill_frame(effective_side(w) * effective_side(h));

            mixed = $urandom_range(20, 70);
            repeat (mixed) begin
                // Now and then the sender holds off until every read has returned.
                if ($urandom_range(0, 39) == 0) wait_drained();
                if ($urandom_range(0, 99) < 65)
                    send_item(OP_READ, PIX_W'($urandom_range(0, (1 << PIX_W) - 1)));
                else
                    send_item(OP_WRITE, PIX_W'($urandom_range(0, (1 << PIX_W) - 1)));
            end
            phase++;
        end

        // Wind down: all reads answered, then a short tail to catch any stray result.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
